@@ src/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants, types and codes of the process-ID allocator table.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int ID_LIMIT   = 1024;

    localparam int ID_W   = $clog2(ID_LIMIT);
    localparam int BND_W  = $clog2(ID_LIMIT + 2);
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = ((ID_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ID_W + SLOT_W + 7) / 8) * 8;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic            used;
        logic [ID_W-1:0] id;
    } t_entry;

    typedef struct packed {
        logic              shift;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [ID_W-1:0]   wr_id;
    } t_ring_ctl;

endpackage

@@ src/pat_cell.sv @@
// ----------------------------------------------------------------------------
// pat_cell
// One table slot: used flag and ID, rotates to its neighbor on shift.
// ----------------------------------------------------------------------------
module pat_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_wr_en,
    input  logic [pat_pkg::ID_W-1:0] i_wr_id,
    input  pat_pkg::t_entry i_nxt,
    output pat_pkg::t_entry o_ent
);
    import pat_pkg::*;

    logic            r_used;
    logic [ID_W-1:0] r_id;

    // write wins over shift: on the last rotation step the shifted-in value
    // is the empty slot being filled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_wr_en) begin
            r_used <= 1'b1;
        end else if (i_shift) begin
            r_used <= i_nxt.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id <= i_wr_id;
        end else if (i_shift) begin
            r_id <= i_nxt.id;
        end
    end

    assign o_ent.used = r_used;
    assign o_ent.id   = r_id;

endmodule

@@ src/pat_ring.sv @@
// ----------------------------------------------------------------------------
// pat_ring
// Circular chain of slot cells; cell 0 is the head seen by the scanner.
// ----------------------------------------------------------------------------
module pat_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pat_pkg::t_ring_ctl i_ctl,
    output pat_pkg::t_entry    o_head
);
    import pat_pkg::*;

    t_entry w_ent [SLOT_COUNT];

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        pat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_ctl.shift),
            .i_wr_en (i_ctl.wr_en && (i_ctl.wr_slot == SLOT_W'(g))),
            .i_wr_id (i_ctl.wr_id),
            .i_nxt   (w_ent[(g + 1) % SLOT_COUNT]),
            .o_ent   (w_ent[g])
        );
    end

    assign o_head = w_ent[0];

endmodule

@@ src/pid_allocator_table.sv @@
// ----------------------------------------------------------------------------
// pid_allocator_table
// Process-ID table serving allocate and lookup items.
// ----------------------------------------------------------------------------
// Input item: s_axis_tuser = operation (0 allocate, 1 lookup),
//   s_axis_tdata[9:0] = query ID. Output item: m_axis_tuser = status
//   (0 ok, 1 table full, 2 not found), m_axis_tdata = given ID, slot index.
// Slots live in a ring of cells that rotates past one comparator at the
// head; a full rotation leaves the ring in place.
// Lookup in range: one rotation, then S_DONE and the output register.
//   Out-of-range lookup, full table, or an allocation inside the safe bound:
//   no rotation, straight to S_DONE.
// Allocation that must search: one rotation per candidate ID tried, k
//   candidates in all. With fewer IDs in use than
//   ID_LIMIT - 1, k is at most SLOT_COUNT; the search gives up after ID_LIMIT.
// One item is in work at a time; s_axis_tready is high only when idle.
// The output register holds one result; while it is stalled the block may
//   still take and work on the next item, then waits to hand it over.
// Reset clears all used flags, the live count, and sets the last issued ID
//   and the safe bound to ID_LIMIT. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_allocator_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pat_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // query_id
    input  logic                             s_axis_tuser,  // operation
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pat_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // given_id, slot_index
    output logic [pat_pkg::STAT_W-1:0]       m_axis_tuser   // status
);
    import pat_pkg::*;

    t_state            r_state, n_state;
    logic              r_op, n_op;
    logic [ID_W-1:0]   r_key, n_key;
    logic [SLOT_W-1:0] r_step, n_step;
    logic              r_hit, n_hit;
    logic [SLOT_W-1:0] r_hit_slot, n_hit_slot;
    logic [BND_W-1:0]  r_best, n_best;
    logic [ID_W-1:0]   r_tries, n_tries;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [BND_W-1:0]  r_last, n_last;
    logic [BND_W-1:0]  r_safe, n_safe;
    logic [STAT_W-1:0] r_res_stat, n_res_stat;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic              r_m_valid, n_m_valid;
    logic [STAT_W-1:0] r_m_stat, n_m_stat;
    logic [ID_W-1:0]   r_m_id, n_m_id;
    logic [SLOT_W-1:0] r_m_slot, n_m_slot;

    t_ring_ctl         w_ctl;
    t_entry            w_head;

    logic              w_match;
    logic              w_above;
    logic              w_fin_hit;
    logic [SLOT_W-1:0] w_fin_slot;
    logic [BND_W-1:0]  w_fin_best;
    logic [BND_W-1:0]  w_cand;
    logic [BND_W-1:0]  w_key_nxt;
    logic [ID_W-1:0]   w_qid;

    pat_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    assign w_qid      = s_axis_tdata[ID_W-1:0];
    assign w_match    = w_head.used && (w_head.id == r_key);
    assign w_above    = w_head.used && (w_head.id > r_key)
                        && (BND_W'(w_head.id) < r_best);
    assign w_fin_hit  = r_hit || w_match;
    assign w_fin_slot = r_hit ? r_hit_slot : r_step;
    assign w_fin_best = w_above ? BND_W'(w_head.id) : r_best;
    assign w_cand     = r_last + BND_W'(1);
    assign w_key_nxt  = BND_W'(r_key) + BND_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_last    <= BND_W'(ID_LIMIT);
            r_safe    <= BND_W'(ID_LIMIT);
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_last    <= n_last;
            r_safe    <= n_safe;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_step     <= n_step;
        r_hit      <= n_hit;
        r_hit_slot <= n_hit_slot;
        r_best     <= n_best;
        r_tries    <= n_tries;
        r_res_stat <= n_res_stat;
        r_res_id   <= n_res_id;
        r_res_slot <= n_res_slot;
        r_m_stat   <= n_m_stat;
        r_m_id     <= n_m_id;
        r_m_slot   <= n_m_slot;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_step     = r_step;
        n_hit      = r_hit;
        n_hit_slot = r_hit_slot;
        n_best     = r_best;
        n_tries    = r_tries;
        n_live     = r_live;
        n_last     = r_last;
        n_safe     = r_safe;
        n_res_stat = r_res_stat;
        n_res_id   = r_res_id;
        n_res_slot = r_res_slot;
        n_m_valid  = r_m_valid;
        n_m_stat   = r_m_stat;
        n_m_id     = r_m_id;
        n_m_slot   = r_m_slot;
        w_ctl      = '0;
        w_ctl.wr_slot = r_live[SLOT_W-1:0];
        s_axis_tready = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_op       = s_axis_tuser;
                    n_step     = '0;
                    n_hit      = 1'b0;
                    n_best     = BND_W'(ID_LIMIT);
                    n_tries    = '0;
                    n_res_stat = STAT_OK;
                    n_res_id   = '0;
                    n_res_slot = '0;
                    n_state    = S_DONE;
                    if (s_axis_tuser == OP_LOOKUP) begin
                        n_key = w_qid;
                        if ((w_qid != '0) && (BND_W'(w_qid) < BND_W'(ID_LIMIT))) begin
                            n_state = S_SCAN;
                        end else begin
                            n_res_stat = STAT_MISSING;
                        end
                    end else if (r_live >= CNT_W'(SLOT_COUNT)) begin
                        n_res_stat = STAT_FULL;
                    end else if (w_cand >= BND_W'(ID_LIMIT)) begin
                        n_key   = ID_W'(1);
                        n_state = S_SCAN;
                    end else if (w_cand >= r_safe) begin
                        n_key   = w_cand[ID_W-1:0];
                        n_state = S_SCAN;
                    end else begin
                        w_ctl.wr_en = 1'b1;
                        w_ctl.wr_id = w_cand[ID_W-1:0];
                        n_live      = r_live + CNT_W'(1);
                        n_last      = w_cand;
                        n_res_id    = w_cand[ID_W-1:0];
                        n_res_slot  = r_live[SLOT_W-1:0];
                    end
                end
            end

            S_SCAN: begin
                w_ctl.shift = 1'b1;
                n_step      = r_step + SLOT_W'(1);
                n_hit       = w_fin_hit;
                n_hit_slot  = w_fin_slot;
                n_best      = w_fin_best;
                if (r_step == SLOT_W'(SLOT_COUNT - 1)) begin
                    if (r_op == OP_LOOKUP) begin
                        n_state = S_DONE;
                        if (w_fin_hit) begin
                            n_res_id   = r_key;
                            n_res_slot = w_fin_slot;
                        end else begin
                            n_res_stat = STAT_MISSING;
                        end
                    end else if (!w_fin_hit) begin
                        // candidate is free: commit while the ring settles
                        w_ctl.wr_en = 1'b1;
                        w_ctl.wr_id = r_key;
                        n_live      = r_live + CNT_W'(1);
                        n_last      = BND_W'(r_key);
                        n_safe      = w_fin_best;
                        n_res_id    = r_key;
                        n_res_slot  = r_live[SLOT_W-1:0];
                        n_state     = S_DONE;
                    end else if (r_tries == ID_W'(ID_LIMIT - 1)) begin
                        n_res_stat = STAT_FULL;
                        n_state    = S_DONE;
                    end else begin
                        n_tries = r_tries + ID_W'(1);
                        n_key   = (w_key_nxt >= BND_W'(ID_LIMIT)) ? ID_W'(1)
                                                                 : w_key_nxt[ID_W-1:0];
                        n_hit   = 1'b0;
                        n_best  = BND_W'(ID_LIMIT);
                    end
                end
            end

            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_stat  = r_res_stat;
                    n_m_id    = r_res_id;
                    n_m_slot  = r_res_slot;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_stat;
    assign m_axis_tdata  = M_TDATA_W'({r_m_slot, r_m_id});

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(SLOT_COUNT))
        else $error("live count beyond slot count");

    a_safe_above_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_safe >= r_last)
        else $error("safe bound below last issued ID");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_stat != STAT_OK)) |-> ((r_m_id == '0) && (r_m_slot == '0)))
        else $error("failed item carries nonzero fields");

    a_live_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live != $past(r_live)) |-> (r_live == $past(r_live) + CNT_W'(1)))
        else $error("live count moved by more than one");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of pid_allocator_table: allocate and lookup items are sent
// in random bursts while the result side stalls on its own pattern. A local
// copy of the ID table predicts each result; results are checked in order.
// ----------------------------------------------------------------------------
module testbench;
    import pat_pkg::*;

    localparam int STALL_LIMIT = 400_000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   pid;
        logic [SLOT_W-1:0] slot;
    } t_pid_reply;

    typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // query_id, zero fill
    logic                 s_axis_tuser = 1'b0; // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // given_id, slot_index, zero fill
    logic [STAT_W-1:0]    m_axis_tuser;        // status

    // local copy of the table
    logic [ID_W-1:0] tbl_id [SLOT_COUNT];
    bit              tbl_used [SLOT_COUNT];
    int unsigned     live_cnt;
    int unsigned     last_given;
    int unsigned     safe_pid;

    t_pid_reply awaited_replies [$];
    int         err_count = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    int         rx_tick = 0;
    t_rx_mode   rx_mode = RX_FREE;

    pid_allocator_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit id_taken(input int unsigned id);
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (tbl_used[s] && tbl_id[s] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned lowest_used_above(input int unsigned id);
        int unsigned best;
        best = ID_LIMIT;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (tbl_used[s] && tbl_id[s] > id && tbl_id[s] < best) best = tbl_id[s];
        end
        return best;
    endfunction

    // updates the local table and returns the result the block must give
    function automatic t_pid_reply apply_request(input logic op, input logic [ID_W-1:0] qid);
        t_pid_reply  r;
        int unsigned cand;
        int unsigned free_slot;
        bit          wrapped;
        bit          found;
        r = '0;
        if (op == OP_LOOKUP) begin
            r.status = STAT_MISSING;
            if (qid > 0 && int'(qid) < ID_LIMIT) begin
                for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
                    if (tbl_used[s] && tbl_id[s] == qid) begin
                        r.status = STAT_OK;
                        r.pid    = qid;
                        r.slot   = s[SLOT_W-1:0];
                    end
                end
            end
            return r;
        end
        r.status = STAT_FULL;
        if (live_cnt >= SLOT_COUNT) return r;
        cand    = last_given + 1;
        wrapped = 1'b0;
        if (cand >= ID_LIMIT) begin
            cand    = 1;
            wrapped = 1'b1;
        end
        if (wrapped || cand >= safe_pid) begin
            found = 1'b0;
            for (int t = 0; t < ID_LIMIT && !found; t++) begin
                if (!id_taken(cand)) begin
                    found = 1'b1;
                end else begin
                    cand++;
                    if (cand >= ID_LIMIT) cand = 1;
                end
            end
            if (!found) return r;
            safe_pid = lowest_used_above(cand);
        end
        free_slot = SLOT_COUNT;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!tbl_used[s]) free_slot = s;
        end
        if (free_slot >= SLOT_COUNT) return r;
        last_given          = cand;
        tbl_id[free_slot]   = cand[ID_W-1:0];
        tbl_used[free_slot] = 1'b1;
        live_cnt++;
        r.status = STAT_OK;
        r.pid    = cand[ID_W-1:0];
        r.slot   = free_slot[SLOT_W-1:0];
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send_item(input logic op, input logic [ID_W-1:0] qid);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W - ID_W){1'b0}}, qid};
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_replies.push_back(apply_request(op, qid));
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_pid_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                report_error("result with nothing expected");
            end else begin
                want = awaited_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    report_error($sformatf("status got %0d want %0d", m_axis_tuser,
                                           want.status));
                if (m_axis_tdata[ID_W-1:0] !== want.pid)
                    report_error($sformatf("given_id got %0d want %0d",
                                           m_axis_tdata[ID_W-1:0], want.pid));
                if (m_axis_tdata[ID_W+SLOT_W-1:ID_W] !== want.slot)
                    report_error($sformatf("slot_index got %0d want %0d",
                                           m_axis_tdata[ID_W+SLOT_W-1:ID_W], want.slot));
            end
        end
    end

    // result-side stall pattern
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_FREE:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:   m_axis_tready <= (rx_tick % 29) >= 11;
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic test_empty_lookups();
        rx_mode = RX_FREE;
        gaps_on = 1'b0;
        send_item(OP_LOOKUP, 10'd0);
        send_item(OP_LOOKUP, 10'd1023);
        send_item(OP_LOOKUP, 10'd1);
        send_item(OP_LOOKUP, 10'd512);
        send_item(OP_LOOKUP, 10'h155);
        send_item(OP_LOOKUP, 10'h2AA);
    endtask

    // first allocate wraps from the reset value and must search
    task automatic test_first_allocations();
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        repeat (6) send_item(OP_ALLOC, ID_W'($urandom_range(0, 1023)));
        send_item(OP_LOOKUP, 10'd1);
        send_item(OP_LOOKUP, 10'd6);
        send_item(OP_LOOKUP, 10'd7);
        send_item(OP_LOOKUP, 10'd0);
        send_item(OP_LOOKUP, 10'd1023);
        drain_replies();
    endtask

    task automatic test_random_mix();
        int          pick;
        int unsigned s;
        logic        op;
        logic [ID_W-1:0] qid;
        for (int phase = 0; phase < 4; phase++) begin
            rx_mode = t_rx_mode'(phase % 3);
            gaps_on = (phase != 2);
            repeat (275) begin
                pick = $urandom_range(0, 99);
                qid  = ID_W'($urandom_range(0, 1023));
                op   = OP_LOOKUP;
                if (pick < 35) begin
                    op = OP_ALLOC;
                end else if (pick < 80 && live_cnt > 0) begin
                    s = $urandom_range(0, live_cnt - 1);
                    if (tbl_used[s]) qid = tbl_id[s];
                end else if (pick < 88) begin
                    case ($urandom_range(0, 2))
                        0:       qid = '0;
                        1:       qid = '1;
                        default: qid = ID_W'(last_given + 1);
                    endcase
                end
                send_item(op, qid);
            end
            drain_replies();
        end
    endtask

    task automatic test_table_full();
        rx_mode = RX_BURSTY;
        gaps_on = 1'b1;
        while (live_cnt < SLOT_COUNT) send_item(OP_ALLOC, '0);
        repeat (3) send_item(OP_ALLOC, '1);
        send_item(OP_LOOKUP, ID_W'(last_given));
        send_item(OP_LOOKUP, ID_W'(last_given - 1));
        send_item(OP_LOOKUP, ID_W'(last_given + 1));
        send_item(OP_LOOKUP, 10'd0);
    endtask

    initial begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            tbl_id[s]   = '0;
            tbl_used[s] = 1'b0;
        end
        live_cnt   = 0;
        last_given = ID_LIMIT;
        safe_pid   = ID_LIMIT;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_lookups();
        test_first_allocations();
        test_random_mix();
        test_table_full();

        drain_replies();
        repeat (SLOT_COUNT + 16) @(posedge i_clk);
        if (awaited_replies.size() != 0)
            report_error($sformatf("%0d results never arrived", awaited_replies.size()));
        if (err_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/pat_pkg.sv
src/pat_cell.sv
src/pat_ring.sv
src/pid_allocator_table.sv
bench/testbench.sv
